>>> design/vpu_pkg.sv
package vpu_pkg;

   localparam int COEF_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int DATA_W         = 32;
   localparam int PIX_W          = 16;
   localparam int DIM_W          = 14;
   localparam int ACT_W          = 2;
   localparam int IDX_W          = 4;
   localparam int CSR_W          = 1;

   // divider: operand prep, one quotient bit per stage, saturation
   localparam int DIV_LAT = DATA_W + 2;

   localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_UNPROJ = 2'd1;
   localparam logic [ACT_W-1:0] ACT_PROJ   = 2'd2;
   localparam logic [ACT_W-1:0] ACT_SKIP   = 2'd3;

   localparam logic [CSR_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_W-1:0] CSR_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd1280;
   localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd720;

   typedef struct packed {
      logic                     valid;
      logic [ACT_W-1:0]         action;
      logic [IDX_W-1:0]         coef_index;
      logic signed [DATA_W-1:0] coef_value;
      logic signed [DATA_W-1:0] depth;
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_z;
      logic signed [DATA_W-1:0] pos_w;
   } ndc_side_type;

   typedef struct packed {
      logic             valid;
      logic [ACT_W-1:0] action;
      logic             fault;
   } tail_side_type;

endpackage

>>> design/viewport_project_unproject.sv
// an item passes stage a, the ndc divide, stage b, the row lanes, the perspective
//   divide, stage e and the output register; throughput: one item per cycle while
//   not held; all stages are pipelined, every divider resolving one quotient bit per stage
// the whole pipeline holds while a result waits on rsp_ready
// reset: synchronous active high, clears valid bits and sets the viewport to 1280x720
// the coefficient matrix is undefined after reset until loaded
module viewport_project_unproject
   import vpu_pkg::*;
#(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_W-1:0]         csr_index,
   input  logic [DIM_W-1:0]         csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ACT_W-1:0]         req_action,
   input  logic [IDX_W-1:0]         req_coef_index,
   input  logic signed [DATA_W-1:0] req_coef_value,
   input  logic signed [PIX_W-1:0]  req_screen_x,
   input  logic signed [PIX_W-1:0]  req_screen_y,
   input  logic signed [DATA_W-1:0] req_depth_in,
   input  logic signed [DATA_W-1:0] req_pos_x,
   input  logic signed [DATA_W-1:0] req_pos_y,
   input  logic signed [DATA_W-1:0] req_pos_z,
   input  logic signed [DATA_W-1:0] req_pos_w,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_world_x,
   output logic signed [DATA_W-1:0] rsp_world_y,
   output logic signed [DATA_W-1:0] rsp_world_z,
   output logic signed [DATA_W-1:0] rsp_world_w,
   output logic signed [PIX_W-1:0]  rsp_pixel_x,
   output logic signed [PIX_W-1:0]  rsp_pixel_y,
   output logic signed [DATA_W-1:0] rsp_depth_out,
   output logic                     rsp_divide_fault
);

   // stored coefficient width and width of a row dot product
   localparam int CS     = (COEF_WIDTH < DATA_W) ? COEF_WIDTH : DATA_W;
   localparam int TW     = CS + DATA_W - FRAC_BITS + 2;
   localparam int NDC_NW = PIX_W + 2;
   localparam int DEN_W  = DIM_W + 1;
   localparam int PM     = DATA_W + 1 + DEN_W;
   localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [PM-1:0] HALF_BIAS = PM'((64'sd1 <<< (FRAC_BITS + 1)) - 1);

   // pipeline advances whenever the output register is free or being drained
   logic rsp_valid_ff;
   logic en;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // viewport registers, zero acts as one
   logic [DIM_W-1:0] width_ff, height_ff, wdim, hdim;
   logic signed [DEN_W-1:0] wden, hden;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      wdim = (width_ff == '0) ? DIM_W'(1) : width_ff;
      hdim = (height_ff == '0) ? DIM_W'(1) : height_ff;
      wden = signed'({1'b0, wdim});
      hden = signed'({1'b0, hdim});
   end

   // stage a: capture the item, form ndc numerators (2*sx - w) and (h - 2*sy)
   ndc_side_type a_side_ff, a_side_in;
   logic signed [NDC_NW-1:0] a_nx_ff, a_ny_ff;

   always_comb begin
      a_side_in.valid      = req_valid;
      a_side_in.action     = req_action;
      a_side_in.coef_index = req_coef_index;
      a_side_in.coef_value = req_coef_value;
      a_side_in.depth      = req_depth_in;
      a_side_in.pos_x      = req_pos_x;
      a_side_in.pos_y      = req_pos_y;
      a_side_in.pos_z      = req_pos_z;
      a_side_in.pos_w      = req_pos_w;
   end

   always_ff @(posedge clock) begin
      if (reset) a_side_ff.valid <= 1'b0;
      else if (en) a_side_ff.valid <= a_side_in.valid;
      if (en) begin
         a_side_ff.action     <= a_side_in.action;
         a_side_ff.coef_index <= a_side_in.coef_index;
         a_side_ff.coef_value <= a_side_in.coef_value;
         a_side_ff.depth      <= a_side_in.depth;
         a_side_ff.pos_x      <= a_side_in.pos_x;
         a_side_ff.pos_y      <= a_side_in.pos_y;
         a_side_ff.pos_z      <= a_side_in.pos_z;
         a_side_ff.pos_w      <= a_side_in.pos_w;
         a_nx_ff <= NDC_NW'(signed'({req_screen_x, 1'b0})) - NDC_NW'(wden);
         a_ny_ff <= NDC_NW'(hden) - NDC_NW'(signed'({req_screen_y, 1'b0}));
      end
   end

   // ndc divide, the rest of the item rides alongside
   logic signed [DATA_W-1:0] ndc_x, ndc_y;
   ndc_side_type b_side;

   vpu_div #(.NW(NDC_NW), .DW(DEN_W), .FRAC(FRAC_BITS)) u_ndc_x (
      .clock(clock), .en(en), .num(a_nx_ff), .den(wden), .quo(ndc_x)
   );
   vpu_div #(.NW(NDC_NW), .DW(DEN_W), .FRAC(FRAC_BITS)) u_ndc_y (
      .clock(clock), .en(en), .num(a_ny_ff), .den(hden), .quo(ndc_y)
   );
   vpu_pipe #(.WIDTH($bits(ndc_side_type)), .DEPTH(DIV_LAT)) u_ndc_side (
      .clock(clock), .reset(reset), .en(en), .d(a_side_ff), .q(b_side)
   );

   // stage b: matrix write for loads, vector select for transforms
   logic signed [CS-1:0]     mat_ff [16];
   logic signed [DATA_W-1:0] vec [4];

   always_ff @(posedge clock) begin
      if (en && b_side.valid && b_side.action == ACT_LOAD) begin
         mat_ff[b_side.coef_index] <= b_side.coef_value[CS-1:0];
      end
   end

   always_comb begin
      if (b_side.action == ACT_UNPROJ) begin
         vec[0] = ndc_x;
         vec[1] = ndc_y;
         vec[2] = b_side.depth;
         vec[3] = ONE;
      end else begin
         vec[0] = b_side.pos_x;
         vec[1] = b_side.pos_y;
         vec[2] = b_side.pos_z;
         vec[3] = b_side.pos_w;
      end
   end

   // four row lanes, one per output component
   logic signed [TW-1:0] t [4];

   for (genvar r = 0; r < 4; r++) begin : g_lane
      logic signed [CS-1:0] row [4];
      always_comb begin
         for (int c = 0; c < 4; c++) row[c] = mat_ff[r*4 + c];
      end
      vpu_lane #(.CS(CS), .FRAC(FRAC_BITS)) u_lane (
         .clock(clock), .en(en), .coef(row), .vec(vec), .dot(t[r])
      );
   end

   tail_side_type b_tail, c_tail, c_tail_f, d_tail;

   always_comb begin
      b_tail.valid  = b_side.valid;
      b_tail.action = b_side.action;
      b_tail.fault  = 1'b0;
   end

   vpu_pipe #(.WIDTH($bits(tail_side_type)), .DEPTH(2)) u_lane_side (
      .clock(clock), .reset(reset), .en(en), .d(b_tail), .q(c_tail)
   );

   // stage c: zero w check, perspective divide of x, y, z by w
   always_comb begin
      c_tail_f       = c_tail;
      c_tail_f.fault = (t[3] == '0);
   end

   logic signed [DATA_W-1:0] qx, qy, qz;

   vpu_div #(.NW(TW), .DW(TW), .FRAC(FRAC_BITS)) u_div_x (
      .clock(clock), .en(en), .num(t[0]), .den(t[3]), .quo(qx)
   );
   vpu_div #(.NW(TW), .DW(TW), .FRAC(FRAC_BITS)) u_div_y (
      .clock(clock), .en(en), .num(t[1]), .den(t[3]), .quo(qy)
   );
   vpu_div #(.NW(TW), .DW(TW), .FRAC(FRAC_BITS)) u_div_z (
      .clock(clock), .en(en), .num(t[2]), .den(t[3]), .quo(qz)
   );
   vpu_pipe #(.WIDTH($bits(tail_side_type)), .DEPTH(DIV_LAT)) u_div_side (
      .clock(clock), .reset(reset), .en(en), .d(c_tail_f), .q(d_tail)
   );

   // stage e: viewport scale products (ndc_x + one)*w and (one - ndc_y)*h
   tail_side_type e_side_ff;
   logic signed [DATA_W-1:0] e_qx_ff, e_qy_ff, e_qz_ff;
   logic signed [PM-1:0]     e_px_ff, e_py_ff;
   logic signed [DATA_W:0]   xsum, ysum;

   always_comb begin
      xsum = (DATA_W+1)'(qx) + (DATA_W+1)'(ONE);
      ysum = (DATA_W+1)'(ONE) - (DATA_W+1)'(qy);
   end

   always_ff @(posedge clock) begin
      if (reset) e_side_ff <= '0;
      else if (en) e_side_ff <= d_tail;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_qx_ff <= qx;
         e_qy_ff <= qy;
         e_qz_ff <= qz;
         e_px_ff <= PM'(xsum) * PM'(wden);
         e_py_ff <= PM'(ysum) * PM'(hden);
      end
   end

   // divide by two ones truncating toward zero, then clamp to pixel range
   function automatic logic signed [PIX_W-1:0] to_pixel(input logic signed [PM-1:0] p);
      logic signed [PM-1:0] biased, q;
      logic signed [PM-1:0] lim_hi, lim_lo;
      begin
         lim_hi = PM'(signed'({1'b0, {(PIX_W-1){1'b1}}}));
         lim_lo = PM'(signed'({1'b1, {(PIX_W-1){1'b0}}}));
         biased = p[PM-1] ? p + HALF_BIAS : p;
         q      = biased >>> (FRAC_BITS + 1);
         if (q > lim_hi) to_pixel = PIX_W'(lim_hi);
         else if (q < lim_lo) to_pixel = PIX_W'(lim_lo);
         else to_pixel = PIX_W'(q);
      end
   endfunction

   // output register: only transforms make a result item
   logic                     out_vld_in, fault_in;
   logic signed [DATA_W-1:0] wx_in, wy_in, wz_in, ww_in, dep_in;
   logic signed [PIX_W-1:0]  pxo_in, pyo_in;
   logic signed [DATA_W-1:0] wx_ff, wy_ff, wz_ff, ww_ff, dep_ff;
   logic signed [PIX_W-1:0]  pxo_ff, pyo_ff;
   logic                     fault_ff;

   always_comb begin
      out_vld_in = e_side_ff.valid &&
                   (e_side_ff.action == ACT_UNPROJ || e_side_ff.action == ACT_PROJ);
      fault_in = 1'b0;
      wx_in    = '0;
      wy_in    = '0;
      wz_in    = '0;
      ww_in    = '0;
      dep_in   = '0;
      pxo_in   = '0;
      pyo_in   = '0;
      if (e_side_ff.fault) begin
         fault_in = 1'b1;
      end else if (e_side_ff.action == ACT_UNPROJ) begin
         wx_in = e_qx_ff;
         wy_in = e_qy_ff;
         wz_in = e_qz_ff;
         ww_in = ONE;
      end else begin
         dep_in = e_qz_ff;
         pxo_in = to_pixel(e_px_ff);
         pyo_in = to_pixel(e_py_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= out_vld_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fault_ff <= fault_in;
         wx_ff    <= wx_in;
         wy_ff    <= wy_in;
         wz_ff    <= wz_in;
         ww_ff    <= ww_in;
         dep_ff   <= dep_in;
         pxo_ff   <= pxo_in;
         pyo_ff   <= pyo_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_world_x      = wx_ff;
   assign rsp_world_y      = wy_ff;
   assign rsp_world_z      = wz_ff;
   assign rsp_world_w      = ww_ff;
   assign rsp_pixel_x      = pxo_ff;
   assign rsp_pixel_y      = pyo_ff;
   assign rsp_depth_out    = dep_ff;
   assign rsp_divide_fault = fault_ff;

   // a faulted item carries nothing but the fault flag
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_fault |-> rsp_world_x == '0 && rsp_world_y == '0 &&
         rsp_world_z == '0 && rsp_world_w == '0 && rsp_pixel_x == '0 &&
         rsp_pixel_y == '0 && rsp_depth_out == '0)
      else $error("faulted item has nonzero fields");

   // an unproject result never carries projection fields
   a_kind_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_world_w != '0 |-> rsp_pixel_x == '0 && rsp_pixel_y == '0 &&
         rsp_depth_out == '0 && !rsp_divide_fault)
      else $error("unproject item carries projection fields");

   a_w_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_world_w != '0 |-> rsp_world_w == ONE)
      else $error("world_w is not one");

endmodule

>>> design/vpu_pipe.sv
module vpu_pipe
   import vpu_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) stage_ff[i] <= '0;
      end else if (en) begin
         stage_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) stage_ff[i] <= stage_ff[i-1];
      end
   end

   assign q = stage_ff[DEPTH-1];

endmodule

>>> design/vpu_div.sv
module vpu_div
   import vpu_pkg::*;
#(
   parameter int NW   = 18,
   parameter int DW   = 15,
   parameter int FRAC = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [NW-1:0]     num,
   input  logic signed [DW-1:0]     den,
   output logic signed [DATA_W-1:0] quo
);

   // quotient = num * 2^FRAC / den, magnitude truncated, saturated to DATA_W bits signed
   localparam int QW   = DATA_W;
   localparam int TOPW = NW + FRAC;
   localparam int CMPW = (TOPW > DW) ? TOPW : DW;

   logic          neg_ff  [QW+1];
   logic          ovf_ff  [QW+1];
   logic [DW-1:0] den_ff  [QW+1];
   logic [DW-1:0] rem_ff  [QW+1];
   logic [QW-1:0] quo_ff  [QW+1];
   logic [QW-1:0] low_ff  [QW+1];
   logic signed [QW-1:0] quo_out_ff;

   logic [NW-1:0]        num_u, nmag;
   logic [DW-1:0]        den_u, dmag;
   logic [TOPW+QW-1:0]   dividend;
   logic [TOPW-1:0]      top;
   logic                 ovf;

   always_comb begin
      num_u    = num;
      den_u    = den;
      nmag     = num_u[NW-1] ? (~num_u + NW'(1)) : num_u;
      dmag     = den_u[DW-1] ? (~den_u + DW'(1)) : den_u;
      dividend = {QW'(0), nmag, FRAC'(0)};
      top      = dividend[TOPW+QW-1:QW];
      ovf      = CMPW'(top) >= CMPW'(dmag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= num_u[NW-1] ^ den_u[DW-1];
         ovf_ff[0] <= ovf;
         den_ff[0] <= dmag;
         rem_ff[0] <= ovf ? '0 : DW'(top);
         quo_ff[0] <= '0;
         low_ff[0] <= dividend[QW-1:0];
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [DW:0] trial;
      logic        ge;
      always_comb begin
         trial = {rem_ff[i], low_ff[i][QW-1]};
         ge    = trial >= {1'b0, den_ff[i]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i+1] <= neg_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
            den_ff[i+1] <= den_ff[i];
            rem_ff[i+1] <= ge ? DW'(trial - {1'b0, den_ff[i]}) : DW'(trial);
            quo_ff[i+1] <= {quo_ff[i][QW-2:0], ge};
            low_ff[i+1] <= {low_ff[i][QW-2:0], 1'b0};
         end
      end
   end

   logic [QW-1:0] mag, limit, clipped;

   always_comb begin
      mag     = ovf_ff[QW] ? '1 : quo_ff[QW];
      limit   = neg_ff[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      clipped = (mag > limit) ? limit : mag;
   end

   always_ff @(posedge clock) begin
      if (en) quo_out_ff <= neg_ff[QW] ? signed'(~clipped + QW'(1)) : signed'(clipped);
   end

   assign quo = quo_out_ff;

endmodule

>>> design/vpu_lane.sv
module vpu_lane
   import vpu_pkg::*;
#(
   parameter int CS   = 32,
   parameter int FRAC = 16,
   localparam int PW  = CS + DATA_W,
   localparam int TW  = PW - FRAC + 2
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [CS-1:0]     coef [4],
   input  logic signed [DATA_W-1:0] vec  [4],
   output logic signed [TW-1:0]     dot
);

   logic signed [PW-1:0] prod_ff [4];
   logic signed [TW-1:0] dot_ff;
   logic signed [TW-1:0] acc;
   logic signed [PW-1:0] shifted;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) prod_ff[c] <= PW'(coef[c]) * PW'(vec[c]);
      end
   end

   // floor shift of each product, then the row sum
   always_comb begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
         shifted = prod_ff[c] >>> FRAC;
         acc     = acc + TW'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (en) dot_ff <= acc;
   end

   assign dot = dot_ff;

endmodule

>>> tb/viewport_project_unproject_tb.sv
module viewport_project_unproject_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vpu_pkg::*;

   localparam longint ONE   = 64'sd1 << FRAC_BITS_DEF;
   localparam longint LO32  = -(64'sd1 << 31);
   localparam longint HI32  = (64'sd1 << 31) - 1;
   // settle time before a register write, covers the full pipeline depth
   localparam int     SETTLE = 100;

   typedef struct {
      int      world_x;
      int      world_y;
      int      world_z;
      int      world_w;
      shortint pixel_x;
      shortint pixel_y;
      int      depth_out;
      bit      divide_fault;
   } point_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_W-1:0]         csr_index = CSR_WIDTH;
   logic [DIM_W-1:0]         csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [ACT_W-1:0]         req_action = ACT_LOAD;
   logic [IDX_W-1:0]         req_coef_index = '0;
   logic signed [DATA_W-1:0] req_coef_value = '0;
   logic signed [PIX_W-1:0]  req_screen_x = '0;
   logic signed [PIX_W-1:0]  req_screen_y = '0;
   logic signed [DATA_W-1:0] req_depth_in = '0;
   logic signed [DATA_W-1:0] req_pos_x = '0;
   logic signed [DATA_W-1:0] req_pos_y = '0;
   logic signed [DATA_W-1:0] req_pos_z = '0;
   logic signed [DATA_W-1:0] req_pos_w = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_world_x;
   logic signed [DATA_W-1:0] rsp_world_y;
   logic signed [DATA_W-1:0] rsp_world_z;
   logic signed [DATA_W-1:0] rsp_world_w;
   logic signed [PIX_W-1:0]  rsp_pixel_x;
   logic signed [PIX_W-1:0]  rsp_pixel_y;
   logic signed [DATA_W-1:0] rsp_depth_out;
   logic                     rsp_divide_fault;

   // predictor state: matrix copy and viewport size
   int            matrix_copy [16];
   bit [DIM_W-1:0] vp_width  = WIDTH_RST;
   bit [DIM_W-1:0] vp_height = HEIGHT_RST;

   point_result_type pending_points [$];
   int            error_count = 0;
   // when set, neither side idles
   bit            calm = 1'b0;
   int            stall_left = 0;

   viewport_project_unproject u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("viewport_project_unproject_tb: errors");
      $finish;
   end

   // ---------------------------------------------------------------
   // fixed-point helpers
   // ---------------------------------------------------------------
   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // num*one/den, truncated toward zero, saturated to 32 bits
   function automatic longint frac_divide(longint num, longint den);
      bit                neg;
      longint unsigned   n, d, lim, qi, r, q;
      neg = (num < 0) != (den < 0);
      n   = num < 0 ? -num : num;
      d   = den < 0 ? -den : den;
      lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
      qi  = n / d;
      r   = n % d;
      if (qi > (lim >> FRAC_BITS_DEF)) begin
         q = lim;
      end else begin
         q = qi << FRAC_BITS_DEF;
         for (int i = 0; i < FRAC_BITS_DEF; i++) begin
            r = r << 1;
            if (r >= d) begin
               r = r - d;
               q = q | (64'd1 << (FRAC_BITS_DEF - 1 - i));
            end
         end
         if (q > lim) q = lim;
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   // transform one item, returns 1 when the item yields a result
   function automatic bit transform_point(input logic [ACT_W-1:0] act,
                                          input longint sx, sy, dz,
                                          input longint px, py, pz, pw,
                                          output point_result_type res);
      longint vw, vh, nx, ny;
      longint vec [4];
      longint t [4];
      res = '{default: 0};
      vw = vp_width == 0 ? 1 : vp_width;
      vh = vp_height == 0 ? 1 : vp_height;
      if (act == ACT_UNPROJ) begin
         vec[0] = clamp((2 * sx - vw) * ONE / vw, LO32, HI32);
         vec[1] = clamp((vh - 2 * sy) * ONE / vh, LO32, HI32);
         vec[2] = dz;
         vec[3] = ONE;
      end else if (act == ACT_PROJ) begin
         vec[0] = px; vec[1] = py; vec[2] = pz; vec[3] = pw;
      end else begin
         return 1'b0;
      end
      for (int r = 0; r < 4; r++) begin
         t[r] = 0;
         // arithmetic shift of a signed product rounds toward minus infinity
         for (int c = 0; c < 4; c++)
            t[r] += (longint'(matrix_copy[r*4+c]) * vec[c]) >>> FRAC_BITS_DEF;
      end
      if (t[3] == 0) begin
         res.divide_fault = 1'b1;
      end else if (act == ACT_UNPROJ) begin
         res.world_x = int'(frac_divide(t[0], t[3]));
         res.world_y = int'(frac_divide(t[1], t[3]));
         res.world_z = int'(frac_divide(t[2], t[3]));
         res.world_w = int'(ONE);
      end else begin
         nx = frac_divide(t[0], t[3]);
         ny = frac_divide(t[1], t[3]);
         res.depth_out = int'(frac_divide(t[2], t[3]));
         res.pixel_x = shortint'(clamp((nx + ONE) * vw / (2 * ONE), -32768, 32767));
         res.pixel_y = shortint'(clamp((ONE - ny) * vh / (2 * ONE), -32768, 32767));
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // request side: one item per call, valid held across back-to-back items
   // ---------------------------------------------------------------
   task automatic send_item(input logic [ACT_W-1:0] act, input int idx, input int coef,
                            input int sx, input int sy, input int dz,
                            input int px, input int py, input int pz, input int pw);
      int               gap;
      point_result_type res;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_coef_index <= idx[IDX_W-1:0];
      req_coef_value <= coef;
      req_screen_x   <= sx[PIX_W-1:0];
      req_screen_y   <= sy[PIX_W-1:0];
      req_depth_in   <= dz;
      req_pos_x      <= px;
      req_pos_y      <= py;
      req_pos_z      <= pz;
      req_pos_w      <= pw;
      do @(posedge clock); while (!req_ready);
      // item taken at this edge, predict against the matrix as it stands
      if (act == ACT_LOAD)
         matrix_copy[idx[IDX_W-1:0]] = coef;
      else if (transform_point(act, longint'(shortint'(sx)), longint'(shortint'(sy)), dz,
                               px, py, pz, pw, res))
         pending_points.push_back(res);
   endtask

   task automatic load_coef(input int idx, input int coef);
      send_item(ACT_LOAD, idx, coef, 0, 0, 0, 0, 0, 0, 0);
   endtask

   task automatic unproject(input int sx, input int sy, input int dz);
      send_item(ACT_UNPROJ, 0, 0, sx, sy, dz, 0, 0, 0, 0);
   endtask

   task automatic project(input int px, input int py, input int pz, input int pw);
      send_item(ACT_PROJ, 0, 0, 0, 0, 0, px, py, pz, pw);
   endtask

   // drop valid and let the pipeline run dry
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      // loads leave nothing to wait on, so give them the pipeline depth too
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_viewport(input int wdt, input int hgt);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= wdt[DIM_W-1:0];
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= hgt[DIM_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vp_width  = wdt[DIM_W-1:0];
      vp_height = hgt[DIM_W-1:0];
   endtask

   // ---------------------------------------------------------------
   // random values
   // ---------------------------------------------------------------
   function automatic int any_word();
      return int'($urandom());
   endfunction

   // mostly moderate coefficients, some zero, some anything
   function automatic int rand_coef();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) return 0;
      if (pick < 22) return any_word();
      return int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
   endfunction

   function automatic int rand_fixed(input int span);
      if ($urandom_range(0, 9) == 0) return any_word();
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic int rand_pixel(input int extent);
      int e;
      if ($urandom_range(0, 7) == 0) return int'(shortint'($urandom()));
      e = extent == 0 ? 1 : extent;
      return int'($urandom_range(0, e - 1));
   endfunction

   task automatic load_random_matrix;
      for (int i = 0; i < 16; i++) load_coef(i, rand_coef());
      // keep w well away from zero most of the time
      if ($urandom_range(0, 3) != 0) load_coef(15, int'($urandom_range(1, 4)) * 65536);
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   task automatic test_identity;
      for (int i = 0; i < 16; i++) load_coef(i, (i % 5 == 0) ? int'(ONE) : 0);
      unproject(0, 0, 0);
      unproject(1279, 719, int'(ONE));
      unproject(-32768, 32767, int'(LO32));
      unproject(32767, -32768, int'(HI32));
      unproject(640, 360, -int'(ONE));
      project(0, 0, 0, int'(ONE));
      project(int'(ONE), -int'(ONE), int'(ONE) / 2, int'(ONE));
      project(int'(HI32), int'(LO32), int'(HI32), int'(ONE));
      project(int'(LO32), int'(HI32), int'(LO32), 1);
      project(int'(ONE), int'(ONE), int'(ONE), -int'(ONE));
      project(1, -1, 12345, int'(LO32));
   endtask

   // w row of all zeros gives a fault on every transform
   task automatic test_zero_w;
      for (int i = 12; i < 16; i++) load_coef(i, 0);
      unproject(100, 200, int'(ONE));
      project(int'(ONE), int'(ONE), int'(ONE), int'(ONE));
      // ignored action, nothing comes back
      send_item(ACT_SKIP, 0, any_word(), 5, 5, 0, any_word(), 0, 0, 0);
      load_coef(15, int'(ONE));
      project(int'(ONE), 0, 0, int'(ONE));
   endtask

   // extreme coefficients drive all three perspective quotients into saturation
   task automatic test_saturation;
      load_coef(0, int'(HI32));
      load_coef(5, int'(LO32));
      load_coef(15, 1);
      unproject(0, 0, int'(HI32));
      project(int'(HI32), int'(HI32), int'(LO32), int'(ONE));
      load_coef(0, int'(ONE));
      load_coef(5, int'(ONE));
      load_coef(15, int'(ONE));
   endtask

   task automatic test_random(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) calm = $urandom_range(0, 3) == 0;
         pick = $urandom_range(0, 99);
         if (pick < 2)
            load_random_matrix();
         else if (pick < 10)
            load_coef($urandom_range(0, 15), rand_coef());
         else if (pick < 13)
            send_item(ACT_SKIP, $urandom_range(0, 15), any_word(), any_word(), any_word(),
                      any_word(), any_word(), any_word(), any_word(), any_word());
         else if (pick < 55)
            unproject(rand_pixel(vp_width), rand_pixel(vp_height), rand_fixed(2 * 65536));
         else
            project(rand_fixed(8 * 65536), rand_fixed(8 * 65536), rand_fixed(8 * 65536),
                    $urandom_range(0, 19) == 0 ? 0 : rand_fixed(4 * 65536));
      end
      calm = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // response side: random stalls, compare against oldest prediction
   // ---------------------------------------------------------------
   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      point_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_points.size() == 0) begin
               $error("result with no item outstanding");
               error_count++;
            end else begin
               want = pending_points.pop_front();
               check_field("world_x", want.world_x, rsp_world_x);
               check_field("world_y", want.world_y, rsp_world_y);
               check_field("world_z", want.world_z, rsp_world_z);
               check_field("world_w", want.world_w, rsp_world_w);
               check_field("pixel_x", want.pixel_x, rsp_pixel_x);
               check_field("pixel_y", want.pixel_y, rsp_pixel_y);
               check_field("depth_out", want.depth_out, rsp_depth_out);
               check_field("divide_fault", want.divide_fault, rsp_divide_fault);
            end
            stall_left = calm ? 0 : $urandom_range(0, 6);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------
   initial begin
      for (int i = 0; i < 16; i++) matrix_copy[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset viewport first: directed cases, then random items
      test_identity();
      test_zero_w();
      test_saturation();
      test_random(320);

      // smallest, 8192 square, zero (acts as one), widest field value, mixed
      write_viewport(1, 1);
      load_random_matrix();
      test_random(320);
      write_viewport(8192, 8192);
      load_random_matrix();
      test_random(320);
      write_viewport(0, 0);
      test_identity();
      test_random(300);
      write_viewport(16383, 1);
      test_random(300);
      write_viewport($urandom_range(1, 8192), $urandom_range(1, 8192));
      load_random_matrix();
      test_random(320);

      drain();
      if (error_count == 0)
         $display("viewport_project_unproject_tb: clean");
      else
         $display("viewport_project_unproject_tb: errors");
      $finish;
   end

endmodule

>>> files.f
design/vpu_pkg.sv
design/vpu_pipe.sv
design/vpu_div.sv
design/vpu_lane.sv
design/viewport_project_unproject.sv
tb/viewport_project_unproject_tb.sv
